// File: rtl/anagram_group_classifier_top_macros.svh
// Assertion macros shared by the anagram group classifier.
`ifndef ANAGRAM_GROUP_CLASSIFIER_TOP_MACROS_SVH
`define ANAGRAM_GROUP_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AGC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("anagram group classifier: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define AGC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("anagram group classifier: next-cycle check failed");

`endif

// File: rtl/agc_pkg.sv
// Package with the constants, types and codes of the anagram group classifier.
`default_nettype none
package agc_pkg;
	localparam int MAX_GROUPS    = 32;
	localparam int MAX_WORD_LEN  = 64;
	localparam int ALPHABET_SIZE = 26;

	localparam int CNT_W  = 7;
	localparam int GRP_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GCNT_W = $clog2(MAX_GROUPS + 1);
	localparam int MEM_W  = 16;

	localparam logic [1:0] ST_JOINED = 2'd0;
	localparam logic [1:0] ST_NEW    = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_LONG   = 2'd3;

	typedef logic [ALPHABET_SIZE-1:0][CNT_W-1:0] key_t;

	typedef struct packed {
		logic take;
		logic g_clr;
		logic g_inc;
		logic set_long;
		logic set_new;
		logic set_join;
		logic set_full;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic              overlong;
		logic              count_zero;
		logic              match;
		logic              last_grp;
		logic              full;
		logic [GCNT_W-1:0] gcount;
	} sts_t;
endpackage
`default_nettype wire

// File: rtl/agc_in_if.sv
// Item channel for incoming letters.
`default_nettype none
interface agc_in_if;
	logic       valid;
	logic       ready;
	logic [4:0] letter;
	logic       has_letter;
	logic       last_of_word;
	logic       start_new_list;

	modport source (output valid, letter, has_letter, last_of_word, start_new_list,
		input ready);
	modport sink (input valid, letter, has_letter, last_of_word, start_new_list,
		output ready);
endinterface
`default_nettype wire

// File: rtl/agc_out_if.sv
// Item channel for classification results.
`default_nettype none
interface agc_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  group_index;
	logic [15:0] position_in_group;
	logic [1:0]  status;
	logic [5:0]  groups_so_far;

	modport source (output valid, group_index, position_in_group, status, groups_so_far,
		input ready);
	modport sink (input valid, group_index, position_in_group, status, groups_so_far,
		output ready);
endinterface
`default_nettype wire

// File: rtl/agc_datapath.sv
// Datapath: letter histogram, group key table, member counts and result registers.
`default_nettype none
module agc_datapath
	import agc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [4:0]  letter,
	input  wire logic        has_letter,
	input  wire logic        start_new_list,
	output logic [4:0]       group_index,
	output logic [15:0]      position_in_group,
	output logic [1:0]       status,
	output logic [5:0]       groups_so_far
);
	key_t              counts_q;
	logic [CNT_W-1:0]  len_q;
	logic              ovl_q;
	logic [GCNT_W-1:0] gcount_q;
	logic [GRP_W-1:0]  g_q;

	key_t              keys_mem [MAX_GROUPS];
	logic [MEM_W-1:0]  members_mem [MAX_GROUPS];
	key_t              rd_key_q;
	logic [MEM_W-1:0]  rd_mem_q;

	logic [GRP_W-1:0]  res_gidx_q;
	logic [MEM_W-1:0]  res_pos_q;
	logic [1:0]        res_st_q;

	logic              letter_ok;
	logic [GRP_W-1:0]  new_idx;
	logic [GRP_W-1:0]  wr_addr;
	logic [MEM_W-1:0]  wr_val;
	logic [MEM_W-1:0]  mem_inc;

	assign letter_ok = has_letter && (int'(letter) < ALPHABET_SIZE);
	assign new_idx   = gcount_q[GRP_W-1:0];
	assign mem_inc   = (rd_mem_q != {MEM_W{1'b1}}) ? rd_mem_q + MEM_W'(1) : rd_mem_q;
	assign wr_addr   = cmd.set_new ? new_idx : g_q;
	assign wr_val    = cmd.set_new ? MEM_W'(1) : mem_inc;

	// Word state: histogram, length and overlong flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= '0;
			len_q    <= '0;
			ovl_q    <= 1'b0;
		end else if (cmd.load) begin
			counts_q <= '0;
			len_q    <= '0;
			ovl_q    <= 1'b0;
		end else if (cmd.take && letter_ok) begin
			if (int'(len_q) >= MAX_WORD_LEN) begin
				ovl_q <= 1'b1;
			end else begin
				len_q <= len_q + CNT_W'(1);
				for (int k = 0; k < ALPHABET_SIZE; k++) begin
					if (int'(letter) == k) begin
						counts_q[k] <= counts_q[k] + CNT_W'(1);
					end
				end
			end
		end
	end

	// Group count and search index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcount_q <= '0;
			g_q      <= '0;
		end else begin
			if (cmd.take && start_new_list) begin
				gcount_q <= '0;
			end else if (cmd.set_new) begin
				gcount_q <= gcount_q + GCNT_W'(1);
			end
			if (cmd.g_clr) begin
				g_q <= '0;
			end else if (cmd.g_inc) begin
				g_q <= g_q + GRP_W'(1);
			end
		end
	end

	// Key table and member counts, one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (cmd.set_new) begin
			keys_mem[new_idx] <= counts_q;
		end
		if (cmd.set_new || cmd.set_join) begin
			members_mem[wr_addr] <= wr_val;
		end
		rd_key_q <= keys_mem[g_q];
		rd_mem_q <= members_mem[g_q];
	end

	// Result held until the output register is free, then handed over.
	always_ff @(posedge clk) begin
		if (cmd.set_long || cmd.set_full) begin
			res_gidx_q <= '0;
			res_pos_q  <= '0;
			res_st_q   <= cmd.set_long ? ST_LONG : ST_FULL;
		end else if (cmd.set_new) begin
			res_gidx_q <= new_idx;
			res_pos_q  <= '0;
			res_st_q   <= ST_NEW;
		end else if (cmd.set_join) begin
			res_gidx_q <= g_q;
			res_pos_q  <= rd_mem_q;
			res_st_q   <= ST_JOINED;
		end
		if (cmd.load) begin
			group_index       <= 5'(res_gidx_q);
			position_in_group <= res_pos_q;
			status            <= res_st_q;
			groups_so_far     <= 6'(gcount_q);
		end
	end

	always_comb begin
		sts.overlong   = ovl_q;
		sts.count_zero = (gcount_q == '0);
		sts.match      = (rd_key_q == counts_q);
		sts.last_grp   = ((GCNT_W'(g_q) + GCNT_W'(1)) >= gcount_q);
		sts.full       = (gcount_q == GCNT_W'(MAX_GROUPS));
		sts.gcount     = gcount_q;
	end
endmodule
`default_nettype wire

// File: rtl/agc_ctrl.sv
// Controller: sequences the end-of-word table search and the output handshake.
`default_nettype none
module agc_ctrl
	import agc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_last,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_CMP   = 3'd3;
	localparam logic [2:0] S_POST  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = in_valid;
				if (in_valid && in_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.g_clr = 1'b1;
				if (sts.overlong) begin
					cmd.set_long = 1'b1;
					state_d      = S_POST;
				end else if (sts.count_zero) begin
					cmd.set_new = 1'b1;
					state_d     = S_POST;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.match) begin
					cmd.set_join = 1'b1;
					state_d      = S_POST;
				end else if (!sts.last_grp) begin
					cmd.g_inc = 1'b1;
					state_d   = S_READ;
				end else if (!sts.full) begin
					cmd.set_new = 1'b1;
					state_d     = S_POST;
				end else begin
					cmd.set_full = 1'b1;
					state_d      = S_POST;
				end
			end
			S_POST: begin
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/anagram_group_classifier_top.sv
// Top level of the anagram group classifier: channels, controller and datapath.
`default_nettype none
// The block takes one lowercase letter per item and keeps a 26-bin letter
// histogram of the current word; that histogram is the anagram key. Items
// without the end-of-word flag are taken one per cycle while no search runs,
// and produce no result. An item with the end-of-word flag starts a search
// of the group key table, which holds up to 32 keys in order of first
// appearance and is read through a single registered memory port: a check
// step, then a read step and a compare step per key compared (at most the
// group count), then a step that hands the result to the output register
// once it is free; the input stalls until then. The result carries the
// group index, the number of earlier members of that group (saturating at
// 65535), the status (joined, new group, table full, word too long) and the
// group count. An item with start_new_list empties the table before it is
// handled; a word in progress continues. Letter codes at or above 26 are
// ignored, and letters beyond 64 in one word mark the word as too long. The
// output register lets the block take the letters of the next word while a
// result waits to be taken. No clearing pass is needed after reset.
module anagram_group_classifier_top
	import agc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	agc_in_if.sink    letters,
	agc_out_if.source results
);
`include "anagram_group_classifier_top_macros.svh"

	cmd_t cmd;
	sts_t sts;

	// The controller owns the state and both handshakes.
	agc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (letters.valid),
		.in_last   (letters.last_of_word),
		.in_ready  (letters.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the histogram, the key table and the result payload.
	agc_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.letter            (letters.letter),
		.has_letter        (letters.has_letter),
		.start_new_list    (letters.start_new_list),
		.group_index       (results.group_index),
		.position_in_group (results.position_in_group),
		.status            (results.status),
		.groups_so_far     (results.groups_so_far)
	);

	// The group count never passes the table size.
	`AGC_ASSERT_NOW(a_count_bound, 1'b1, sts.gcount <= GCNT_W'(MAX_GROUPS))
	// A new group is only opened while the table has room.
	`AGC_ASSERT_NOW(a_new_has_room, cmd.set_new, !sts.full)
	// After the end of a word is taken, the input stalls for the search.
	`AGC_ASSERT_NEXT(a_busy_after_word,
		letters.valid && letters.ready && letters.last_of_word, !letters.ready)
endmodule
`default_nettype wire
